[rtl/mbps_pkg.sv]
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared types, register codes and defaults for the masked byte pattern
// search core.
// ----------------------------------------------------------------------------
package mbps_pkg;

   localparam int PatternMaxDefault = 16;
   localparam int CaptureMaxDefault = 8;

   // pattern bytes held by the two pattern registers
   localparam int RegBytes      = 16;
   localparam int CsrIndexWidth = 3;
   localparam int LenWidth      = 5;
   localparam int OffsetWidth   = 4;
   localparam int CapLenWidth   = 4;

   localparam logic [CsrIndexWidth-1:0] CSR_REGION_BASE   = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_PATTERN_LOW   = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_PATTERN_HIGH  = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_WILDCARD_MASK = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_PATTERN_LEN   = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CSR_CAPTURE_OFS   = 3'd5;
   localparam logic [CsrIndexWidth-1:0] CSR_CAPTURE_LEN   = 3'd6;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [63:0] match_address;
      logic [63:0] captured_value;
   } rsp_type;

   typedef struct packed {
      logic [63:0]            region_base;
      logic [63:0]            pattern_low_bytes;
      logic [63:0]            pattern_high_bytes;
      logic [15:0]            wildcard_mask;
      logic [LenWidth-1:0]    pattern_len;
      logic [OffsetWidth-1:0] capture_offset;
      logic [CapLenWidth-1:0] capture_len;
   } cfg_type;

   typedef struct packed {
      logic        hit;
      logic [63:0] address;
      logic [63:0] capture;
   } match_type;

endpackage

[rtl/mbps_csr.sv]
// ----------------------------------------------------------------------------
// mbps_csr
// Configuration register file. Writes to an unknown index are dropped.
// ----------------------------------------------------------------------------
module mbps_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mbps_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [63:0]                         csr_data,
   output mbps_pkg::cfg_type                   cfg
);
   import mbps_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_REGION_BASE:   cfg_in.region_base        = csr_data;
            CSR_PATTERN_LOW:   cfg_in.pattern_low_bytes  = csr_data;
            CSR_PATTERN_HIGH:  cfg_in.pattern_high_bytes = csr_data;
            CSR_WILDCARD_MASK: cfg_in.wildcard_mask      = csr_data[15:0];
            CSR_PATTERN_LEN:   cfg_in.pattern_len        = csr_data[LenWidth-1:0];
            CSR_CAPTURE_OFS:   cfg_in.capture_offset     = csr_data[OffsetWidth-1:0];
            CSR_CAPTURE_LEN:   cfg_in.capture_len        = csr_data[CapLenWidth-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[rtl/mbps_match.sv]
// ----------------------------------------------------------------------------
// mbps_match
// Window shift, masked compare of all pattern positions in parallel, byte
// capture and match address.
// ----------------------------------------------------------------------------
module mbps_match #(
   parameter int PatternMax = mbps_pkg::PatternMaxDefault,
   parameter int CaptureMax = mbps_pkg::CaptureMaxDefault
) (
   input  mbps_pkg::cfg_type         cfg,
   input  logic [PatternMax-1:0][7:0] window,
   input  logic [63:0]               byte_count,
   input  logic [7:0]                data_byte,
   output logic [PatternMax-1:0][7:0] window_next,
   output logic [63:0]               byte_count_next,
   output mbps_pkg::match_type       result
);
   import mbps_pkg::*;

   localparam int IdxW = (PatternMax > 1) ? $clog2(PatternMax) : 1;

   logic [8*RegBytes-1:0] pattern;
   logic                  len_ok;
   logic                  enough;
   logic                  mismatch;
   logic [63:0]           capture;

   assign pattern = {cfg.pattern_high_bytes, cfg.pattern_low_bytes};

   always_comb begin
      for (int i = 0; i < PatternMax - 1; i++) begin
         window_next[i] = window[i+1];
      end
      window_next[PatternMax-1] = data_byte;
   end

   // count saturates at all ones
   assign byte_count_next = (&byte_count) ? byte_count : byte_count + 64'd1;

   assign len_ok = (cfg.pattern_len != '0) && (int'(cfg.pattern_len) <= PatternMax) &&
                   (int'(cfg.pattern_len) <= RegBytes);
   assign enough = byte_count_next >= {{(64-LenWidth){1'b0}}, cfg.pattern_len};

   // pattern position j sits at window slot PatternMax - len + j
   always_comb begin
      int idx;
      mismatch = 1'b0;
      for (int j = 0; j < RegBytes; j++) begin
         idx = PatternMax - int'(cfg.pattern_len) + j;
         if ((j < int'(cfg.pattern_len)) && !cfg.wildcard_mask[j] &&
             (window_next[idx[IdxW-1:0]] != pattern[8*j +: 8])) begin
            mismatch = 1'b1;
         end
      end
   end

   always_comb begin
      int idx;
      int pos;
      int clen;
      capture = '0;
      clen = (int'(cfg.capture_len) > CaptureMax) ? CaptureMax : int'(cfg.capture_len);
      for (int i = 0; i < CaptureMax; i++) begin
         pos = int'(cfg.capture_offset) + i;
         idx = PatternMax - int'(cfg.pattern_len) + pos;
         if ((i < clen) && (pos < int'(cfg.pattern_len))) begin
            capture[8*i +: 8] = window_next[idx[IdxW-1:0]];
         end
      end
   end

   assign result.hit     = len_ok && enough && !mismatch;
   assign result.address = cfg.region_base +
                           (byte_count_next - {{(64-LenWidth){1'b0}}, cfg.pattern_len});
   assign result.capture = capture;

endmodule

[rtl/masked_byte_pattern_search_core.sv]
// Path: a transferred byte is held in the input register, and its result is then
// registered into the result register (rsp_valid) once that is empty or being drained.
// Throughput: one byte per cycle; the input register advances whenever the
// result register is empty or being drained.
// Reset: synchronous, clears configuration, region count, match flag and all
// valid flags.
// ----------------------------------------------------------------------------
// masked_byte_pattern_search_core
// Wildcard byte signature scan over a byte stream, one result per region.
// ----------------------------------------------------------------------------
module masked_byte_pattern_search_core #(
   parameter int PatternMax = mbps_pkg::PatternMaxDefault,
   parameter int CaptureMax = mbps_pkg::CaptureMaxDefault
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  mbps_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output mbps_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mbps_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [63:0]                         csr_data
);
   import mbps_pkg::*;

   cfg_type                   cfg;
   match_type                 match;
   logic [PatternMax-1:0][7:0] window_ff;
   logic [PatternMax-1:0][7:0] window_in;
   logic [63:0]               count_ff;
   logic [63:0]               count_in;
   logic                      done_ff;
   logic                      s1_valid_ff;
   req_type                   s1_item_ff;
   logic                      rsp_valid_ff;
   rsp_type                   rsp_data_ff;
   logic                      advance;
   logic                      produce;

   mbps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   mbps_match #(
      .PatternMax (PatternMax),
      .CaptureMax (CaptureMax)
   ) u_match (
      .cfg             (cfg),
      .window          (window_ff),
      .byte_count      (count_ff),
      .data_byte       (s1_item_ff.data_byte),
      .window_next     (window_in),
      .byte_count_next (count_in),
      .result          (match)
   );

   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   // once matched, the rest of the region is dropped silently
   assign produce   = advance && !done_ff && (match.hit || s1_item_ff.last_byte);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         done_ff      <= 1'b0;
      end else begin
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (produce) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (advance) begin
            if (s1_item_ff.last_byte) begin
               count_ff <= '0;
               done_ff  <= 1'b0;
            end else if (!done_ff) begin
               count_ff <= count_in;
               if (match.hit) begin
                  done_ff <= 1'b1;
               end
            end
         end
      end
   end

   // window contents older than the count are never compared, so no reset
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_item_ff <= req_data;
      end
      if (advance && !done_ff) begin
         window_ff <= window_in;
      end
      if (produce) begin
         rsp_data_ff.found          <= match.hit;
         rsp_data_ff.match_address  <= match.hit ? match.address : 64'd0;
         rsp_data_ff.captured_value <= match.hit ? match.capture : 64'd0;
      end
   end

endmodule

[rtl/mbps_checker.sv]
// ----------------------------------------------------------------------------
// mbps_checker
// Port-level checks for the masked byte pattern search core.
// ----------------------------------------------------------------------------
module mbps_checker (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input mbps_pkg::rsp_type   rsp_data
);
   import mbps_pkg::*;

   // nothing comes out in the cycle after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped before transfer");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("rsp_data changed while stalled");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |->
         (rsp_data.match_address == 64'd0) && (rsp_data.captured_value == 64'd0))
      else $error("not-found result carries nonzero address or capture");

endmodule

bind masked_byte_pattern_search_core mbps_checker u_checker (.*);
